@@ rtl/mchm_pkg.sv @@
// Package of shared constants, types and codes for the marker code Hamming matcher.
package mchm_pkg;

    localparam int MAX_MARKERS = 256;
    localparam int CODE_BITS   = 49;
    localparam int ROTATIONS   = 4;

    localparam int MARKER_W    = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int ROT_W       = $clog2(ROTATIONS);
    localparam int IDX_W       = MARKER_W + ROT_W;
    localparam int TABLE_DEPTH = MAX_MARKERS * ROTATIONS;
    localparam int MCNT_W      = $clog2(MAX_MARKERS + 1);
    localparam int TOTAL_W     = MCNT_W + ROT_W;
    localparam int DIST_W      = $clog2(CODE_BITS + 1);

    localparam int GROUP_W     = 8;
    localparam int N_GROUPS    = (CODE_BITS + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W       = N_GROUPS * GROUP_W;
    localparam int GCNT_W      = $clog2(GROUP_W + 1);

    localparam int OP_W        = 1;
    localparam int ENTRY_M_W   = 8;
    localparam int ENTRY_R_W   = 2;
    localparam int WORD_W      = 49;
    localparam int SIDE_W      = 3;
    localparam int SQ_W        = 2 * SIDE_W;
    localparam int COUNT_W     = 9;
    localparam int MAXC_W      = 6;
    localparam int OUT_ID_W    = 8;
    localparam int OUT_ROT_W   = 2;
    localparam int OUT_DIST_W  = 6;
    localparam int CMP_W       = (DIST_W > MAXC_W) ? DIST_W : MAXC_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_BITS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORRECTION = 2'd2;

    localparam logic [OP_W-1:0] OP_WRITE    = 1'b0;
    localparam logic [OP_W-1:0] OP_IDENTIFY = 1'b1;

    localparam logic [SIDE_W-1:0]  SIDE_RESET  = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_RESET = '0;
    localparam logic [MAXC_W-1:0]  MAXC_RESET  = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_seq_state;

    typedef struct packed {
        logic             issue_valid;
        logic [IDX_W-1:0] issue_idx;
        logic             flush;
        logic             busy;
        logic             scanning;
    } t_seq_ctrl;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  tag;
        logic [DIST_W-1:0] distance;
    } t_dist_res;

endpackage

@@ rtl/marker_code_hamming_matcher_top.sv @@
// Top level of the marker code Hamming matcher with the code table and configuration registers.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------------------
//  in       | input     | i_in_valid / o_in_stall    | opcode, entry_marker, entry_rotation, code
//  out      | output    | o_out_valid / i_out_stall  | found, marker_id, rotation, distance
//  cfg      | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A write word does not stall the input. An identify word holds off the input until its result
// word is loaded. The code table has a single read port and is read one entry per cycle during
// a scan. A stalled earlier result delays the load of the next one. Reset is synchronous and
// active low; the code table has no reset and no clearing pass. A result word waiting under
// stall does not block the next input.
module marker_code_hamming_matcher_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [mchm_pkg::OP_W-1:0]        i_opcode,
    input  logic [mchm_pkg::ENTRY_M_W-1:0]   i_entry_marker,
    input  logic [mchm_pkg::ENTRY_R_W-1:0]   i_entry_rotation,
    input  logic [mchm_pkg::WORD_W-1:0]      i_code_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [mchm_pkg::OUT_ID_W-1:0]    o_marker_id,
    output logic [mchm_pkg::OUT_ROT_W-1:0]   o_best_rotation,
    output logic [mchm_pkg::OUT_DIST_W-1:0]  o_best_distance,
    input  logic                             i_cfg_we,
    input  logic [mchm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mchm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mchm_pkg::*;

    logic [CODE_BITS-1:0] r_code_table [TABLE_DEPTH];

    logic [SIDE_W-1:0]    r_side_bits;
    logic [COUNT_W-1:0]   r_marker_count;
    logic [MAXC_W-1:0]    r_max_corr;

    logic [CODE_BITS-1:0] r_cand;
    logic [CODE_BITS-1:0] r_mask;
    logic [CODE_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_rd_tag;
    logic                 r_rd_valid;

    logic                 w_accept;
    logic                 w_start;
    logic                 w_write;
    logic [IDX_W-1:0]     w_wr_idx;
    logic [CODE_BITS-1:0] w_word;
    logic [SQ_W-1:0]      w_sq;
    logic [CODE_BITS-1:0] w_mask;
    logic [MCNT_W-1:0]    w_markers;
    logic [TOTAL_W-1:0]   w_total;

    t_seq_ctrl            w_ctrl;
    t_dist_res            w_dist;

    assign o_in_stall = w_ctrl.busy;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_start    = w_accept && (i_opcode == OP_IDENTIFY);
    assign w_write    = w_accept && (i_opcode == OP_WRITE) &&
                        (32'(i_entry_marker) < MAX_MARKERS);
    assign w_wr_idx   = {MARKER_W'(i_entry_marker), ROT_W'(i_entry_rotation)};
    assign w_word     = CODE_BITS'(i_code_word);
    assign w_sq       = SQ_W'(r_side_bits) * SQ_W'(r_side_bits);
    assign w_mask     = ~({CODE_BITS{1'b1}} << w_sq);
    assign w_markers  = (32'(r_marker_count) > MAX_MARKERS) ? MCNT_W'(MAX_MARKERS)
                                                            : MCNT_W'(r_marker_count);
    assign w_total    = {w_markers, {ROT_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_bits    <= SIDE_RESET;
            r_marker_count <= COUNT_RESET;
            r_max_corr     <= MAXC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIDE_BITS:      r_side_bits    <= SIDE_W'(i_cfg_data);
                CFG_MARKER_COUNT:   r_marker_count <= COUNT_W'(i_cfg_data);
                CFG_MAX_CORRECTION: r_max_corr     <= MAXC_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_code_table[w_wr_idx] <= w_word;
        end
        if (w_ctrl.issue_valid) begin
            r_rd_data <= r_code_table[w_ctrl.issue_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_ctrl.issue_valid;
        end
        r_rd_tag <= w_ctrl.issue_idx;
        if (w_start) begin
            r_cand <= w_word;
            r_mask <= w_mask;
        end
    end

    mchm_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_tag   (r_rd_tag),
        .i_flush (w_ctrl.flush),
        .i_entry (r_rd_data),
        .i_cand  (r_cand),
        .i_mask  (r_mask),
        .o_res   (w_dist)
    );

    mchm_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_start),
        .i_total         (w_total),
        .i_max_corr      (r_max_corr),
        .i_dist          (w_dist),
        .o_ctrl          (w_ctrl),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_marker_id     (o_marker_id),
        .o_best_rotation (o_best_rotation),
        .o_best_distance (o_best_distance)
    );

    a_dist_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist.valid |-> w_ctrl.scanning)
        else $error("distance word outside a scan");

    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.scanning |-> o_in_stall)
        else $error("input word accepted during a scan");

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> ((o_best_distance == '0) && (o_marker_id == '0) &&
                                        (o_best_rotation == '0)))
        else $error("result without a match is not zero");

    a_flush_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.flush |=> !w_ctrl.scanning)
        else $error("scan continues after its end");

endmodule

@@ rtl/mchm_dist.sv @@
// Two-stage Hamming distance unit shared by every table entry of a scan.
module mchm_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mchm_pkg::IDX_W-1:0]    i_tag,
    input  logic                          i_flush,
    input  logic [mchm_pkg::CODE_BITS-1:0] i_entry,
    input  logic [mchm_pkg::CODE_BITS-1:0] i_cand,
    input  logic [mchm_pkg::CODE_BITS-1:0] i_mask,
    output mchm_pkg::t_dist_res           o_res
);
    import mchm_pkg::*;

    function automatic logic [GCNT_W-1:0] f_grp_count(input logic [GROUP_W-1:0] v);
        logic [GCNT_W-1:0] c;
        c = '0;
        for (int b = 0; b < GROUP_W; b++) begin
            c = c + GCNT_W'(v[b]);
        end
        return c;
    endfunction

    logic [PAD_W-1:0]   w_diff;
    logic [DIST_W-1:0]  w_sum;

    logic               r_a_valid;
    logic [IDX_W-1:0]   r_a_tag;
    logic [GCNT_W-1:0]  r_a_cnt [N_GROUPS];

    logic               r_b_valid;
    logic [IDX_W-1:0]   r_b_tag;
    logic [DIST_W-1:0]  r_b_dist;

    assign w_diff = PAD_W'((i_entry ^ i_cand) & i_mask);

    always_comb begin
        w_sum = '0;
        for (int g = 0; g < N_GROUPS; g++) begin
            w_sum = w_sum + DIST_W'(r_a_cnt[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid && !i_flush;
            r_b_valid <= r_a_valid && !i_flush;
        end
        r_a_tag <= i_tag;
        for (int g = 0; g < N_GROUPS; g++) begin
            r_a_cnt[g] <= f_grp_count(w_diff[g*GROUP_W +: GROUP_W]);
        end
        r_b_tag  <= r_a_tag;
        r_b_dist <= w_sum;
    end

    assign o_res.valid    = r_b_valid;
    assign o_res.tag      = r_b_tag;
    assign o_res.distance = r_b_dist;

endmodule

@@ rtl/mchm_seq.sv @@
// Scan sequencer: issues table reads, keeps the best match and holds the result word.
module mchm_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mchm_pkg::TOTAL_W-1:0]  i_total,
    input  logic [mchm_pkg::MAXC_W-1:0]   i_max_corr,
    input  mchm_pkg::t_dist_res           i_dist,
    output mchm_pkg::t_seq_ctrl           o_ctrl,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [mchm_pkg::OUT_ID_W-1:0]   o_marker_id,
    output logic [mchm_pkg::OUT_ROT_W-1:0]  o_best_rotation,
    output logic [mchm_pkg::OUT_DIST_W-1:0] o_best_distance
);
    import mchm_pkg::*;

    t_seq_state          r_state, n_state;
    logic [TOTAL_W-1:0]  r_cnt, n_cnt;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [DIST_W-1:0]   r_best_dist, n_best_dist;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found;
    logic [IDX_W-1:0]    r_out_idx;
    logic [DIST_W-1:0]   r_out_dist;

    logic                w_upd;
    logic [DIST_W-1:0]   w_new_best;
    logic                w_last_rot;
    logic                w_last_all;
    logic                w_end;
    logic                w_load;
    logic                w_issue;

    assign w_upd      = !r_found || (i_dist.distance < r_best_dist);
    assign w_new_best = w_upd ? i_dist.distance : r_best_dist;
    assign w_last_rot = i_dist.tag[ROT_W-1:0] == ROT_W'(ROTATIONS - 1);
    assign w_last_all = TOTAL_W'(i_dist.tag) == (r_total - TOTAL_W'(1));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        n_out_valid = r_out_valid && i_out_stall;
        w_end       = 1'b0;
        w_load      = 1'b0;
        w_issue     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cnt       = '0;
                    n_total     = i_total;
                    n_found     = 1'b0;
                    n_best_idx  = '0;
                    n_best_dist = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_total == '0) begin
                    w_end = 1'b1;
                end else if (i_dist.valid) begin
                    n_found = 1'b1;
                    if (w_upd) begin
                        n_best_idx  = i_dist.tag;
                        n_best_dist = i_dist.distance;
                    end
                    if (w_last_rot &&
                        (w_last_all || (CMP_W'(w_new_best) <= CMP_W'(i_max_corr)))) begin
                        w_end = 1'b1;
                    end
                end
                w_issue = (r_cnt < r_total) && !w_end;
                if (w_issue) begin
                    n_cnt = r_cnt + TOTAL_W'(1);
                end
                if (w_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
        end
        r_best_idx  <= n_best_idx;
        r_best_dist <= n_best_dist;
        if (w_load) begin
            r_out_found <= r_found;
            r_out_idx   <= r_best_idx;
            r_out_dist  <= r_best_dist;
        end
    end

    assign o_ctrl.issue_valid = w_issue;
    assign o_ctrl.issue_idx   = r_cnt[IDX_W-1:0];
    assign o_ctrl.flush       = w_end;
    assign o_ctrl.busy        = r_state != ST_IDLE;
    assign o_ctrl.scanning    = r_state == ST_SCAN;

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out_found;
    assign o_marker_id     = OUT_ID_W'(r_out_idx[IDX_W-1:ROT_W]);
    assign o_best_rotation = OUT_ROT_W'(r_out_idx[ROT_W-1:0]);
    assign o_best_distance = OUT_DIST_W'(r_out_dist);

endmodule
